>>> rtl/core/msci_pkg.sv
// Shared types, start code values and lookup functions for the start code indexer.
package msci_pkg;

  localparam int ENTRY_BITS = 48;

  typedef logic [ENTRY_BITS-1:0] entry_pos_t;

  typedef struct packed {
    logic [7:0] es_byte;
    entry_pos_t byte_position;
  } es_word_t;

  typedef struct packed {
    logic        record_kind;
    entry_pos_t  entry_start;
    logic [1:0]  picture_type;
    logic        starts_entry;
    logic [12:0] width;
    logic [12:0] height;
    logic [3:0]  aspect_code;
    logic [15:0] frame_rate;
  } rec_word_t;

  typedef enum logic [1:0] {
    HK_SCAN,
    HK_SEQ,
    HK_SKIP,
    HK_PIC
  } hdr_kind_t;

  localparam logic [7:0] CODE_SEQUENCE = 8'hB3;
  localparam logic [7:0] CODE_GOP      = 8'hB8;
  localparam logic [7:0] CODE_PICTURE  = 8'h00;

  localparam logic [23:0] WINDOW_ONES   = 24'hFFFFFF;
  localparam logic [23:0] WINDOW_PREFIX = 24'h000001;

  localparam logic REC_SEQUENCE = 1'b0;
  localparam logic REC_PICTURE  = 1'b1;

  localparam logic [1:0] PIC_NONE = 2'd0;
  localparam logic [1:0] PIC_I    = 2'd1;

  localparam logic [3:0] SEQ_FIELD_BYTES = 4'd4;
  localparam logic [3:0] SEQ_SKIP_BYTES  = 4'd8;
  localparam logic [3:0] SEQ_TAIL_BYTES  = 4'd4;
  localparam logic [3:0] PIC_FIELD_BYTES = 4'd2;

  function automatic logic [12:0] round16(input logic [11:0] v);
    logic [12:0] s;
    s = {1'b0, v} + 13'd15;
    return {s[12:4], 4'b0000};
  endfunction

  function automatic logic [15:0] frame_rate_of(input logic [3:0] code);
    logic [15:0] r;
    unique case (code)
      4'd1:    r = 16'd23976;
      4'd2:    r = 16'd24000;
      4'd3:    r = 16'd25000;
      4'd4:    r = 16'd29970;
      4'd5:    r = 16'd30000;
      4'd6:    r = 16'd50000;
      4'd7:    r = 16'd59940;
      4'd8:    r = 16'd60000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/msci_scan.sv
// Start code scanner, header field capture and entry tracking, one byte per cycle while take is high.
module msci_scan
  import msci_pkg::*;
#(
  parameter int POSITION_BITS = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  es_word_t  word,
  output logic      found,
  output rec_word_t rec
);

  logic [23:0]              window, window_next;
  logic                     seq_seen, seq_seen_next;
  logic                     at_gop, at_gop_next;
  hdr_kind_t                kind, kind_next;
  logic [3:0]               btt, btt_next;
  logic [31:0]              hshift, hshift_next;
  logic [POSITION_BITS-1:0] entry_pos, entry_pos_next;
  logic [POSITION_BITS-1:0] hdr_pos, hdr_pos_next;

  logic [POSITION_BITS-1:0] pos;
  logic [31:0]              shift_in;
  logic                     last;
  logic [2:0]               pic_code;
  logic                     pic_legal;

  assign pos       = POSITION_BITS'(word.byte_position);
  assign shift_in  = {hshift[23:0], word.es_byte};
  assign last      = (btt <= 4'd1);
  assign pic_code  = shift_in[5:3];
  assign pic_legal = (pic_code != 3'd0) && !pic_code[2];

  always_comb begin
    window_next    = window;
    seq_seen_next  = seq_seen;
    at_gop_next    = at_gop;
    kind_next      = kind;
    btt_next       = btt;
    hshift_next    = hshift;
    entry_pos_next = entry_pos;
    hdr_pos_next   = hdr_pos;
    if (take) begin
      unique case (kind)
        HK_SCAN: begin
          if (window != WINDOW_PREFIX) begin
            window_next = {window[15:0], word.es_byte};
          end else begin
            window_next = WINDOW_ONES;
            if (word.es_byte == CODE_SEQUENCE) begin
              entry_pos_next = pos;
              at_gop_next    = 1'b1;
              hshift_next    = '0;
              if (seq_seen) begin
                kind_next = HK_SKIP;
                btt_next  = SEQ_SKIP_BYTES;
              end else begin
                seq_seen_next = 1'b1;
                kind_next     = HK_SEQ;
                btt_next      = SEQ_FIELD_BYTES;
              end
            end else if (word.es_byte == CODE_GOP) begin
              if (seq_seen && !at_gop) begin
                entry_pos_next = pos;
                at_gop_next    = 1'b1;
              end
            end else if (word.es_byte == CODE_PICTURE) begin
              if (seq_seen) begin
                kind_next    = HK_PIC;
                btt_next     = PIC_FIELD_BYTES;
                hshift_next  = '0;
                hdr_pos_next = pos;
              end
            end
          end
        end
        HK_SKIP: begin
          btt_next = last ? 4'd0 : btt - 4'd1;
          if (last) begin
            kind_next = HK_SCAN;
          end
        end
        HK_SEQ: begin
          btt_next    = last ? 4'd0 : btt - 4'd1;
          hshift_next = shift_in;
          if (last) begin
            kind_next = HK_SKIP;
            btt_next  = SEQ_TAIL_BYTES;
          end
        end
        HK_PIC: begin
          btt_next    = last ? 4'd0 : btt - 4'd1;
          hshift_next = shift_in;
          if (last) begin
            kind_next = HK_SCAN;
            if (pic_legal) begin
              if (!at_gop) begin
                entry_pos_next = hdr_pos;
              end
              at_gop_next = 1'b0;
            end
          end
        end
        default: begin
          kind_next = HK_SCAN;
        end
      endcase
    end
  end

  always_comb begin
    rec             = '0;
    rec.entry_start = entry_pos_t'(entry_pos);
    found           = 1'b0;
    unique case (kind)
      HK_SEQ: begin
        found           = take && last;
        rec.record_kind = REC_SEQUENCE;
        rec.width       = round16(shift_in[31:20]);
        rec.height      = round16(shift_in[19:8]);
        rec.aspect_code = shift_in[7:4];
        rec.frame_rate  = frame_rate_of(shift_in[3:0]);
      end
      HK_PIC: begin
        found            = take && last && pic_legal;
        rec.record_kind  = REC_PICTURE;
        rec.picture_type = pic_code[1:0];
        rec.starts_entry = (pic_code[1:0] == PIC_I);
      end
      default: begin
        found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_ONES;
      seq_seen  <= 1'b0;
      at_gop    <= 1'b0;
      kind      <= HK_SCAN;
      btt       <= 4'd0;
      hshift    <= '0;
      entry_pos <= '0;
      hdr_pos   <= '0;
    end else begin
      window    <= window_next;
      seq_seen  <= seq_seen_next;
      at_gop    <= at_gop_next;
      kind      <= kind_next;
      btt       <= btt_next;
      hshift    <= hshift_next;
      entry_pos <= entry_pos_next;
      hdr_pos   <= hdr_pos_next;
    end
  end

endmodule

>>> rtl/core/mpeg2_video_start_code_indexer.sv
// Top level of the MPEG-2 video start code indexer with its output register and skid stage.
// The block takes one stream byte per cycle unless stalled and passes its record, if any,
// through the output register. Records come from the first sequence header, as sizes, aspect
// code and frame rate, and from each legal picture header, as picture type and entry start.
// The scan window and header state are updated for each byte taken, so one word is taken in
// every cycle while the record side flows. A stalled record is held in the output register
// and one further record in a skid register; stall on the byte side is raised only while that
// skid register is full. POSITION_BITS sets the width of the stored positions.
module mpeg2_video_start_code_indexer
  import msci_pkg::*;
#(
  parameter int POSITION_BITS = 48
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      es_valid,
  output logic      es_stall,
  input  es_word_t  es_word,
  output logic      rec_valid,
  input  logic      rec_stall,
  output rec_word_t rec_word
);

  logic      take;
  logic      found;
  rec_word_t rec_new;
  logic      out_valid;
  rec_word_t out_word;
  logic      skid_valid;
  rec_word_t skid_word;
  logic      out_free;

  assign take     = es_valid && !skid_valid;
  assign es_stall = skid_valid;
  assign out_free = !out_valid || !rec_stall;

  msci_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (es_word),
    .found(found),
    .rec  (rec_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= found;
      end
    end else if (found) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (found) begin
        out_word <= rec_new;
      end
    end else if (found) begin
      skid_word <= rec_new;
    end
  end

  assign rec_valid = out_valid;
  assign rec_word  = out_word;

endmodule

>>> rtl/core/msci_checker.sv
// Port-level checks of the start code indexer and their binding to the top level.
module msci_checker
  import msci_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      es_stall,
  input logic      rec_valid,
  input logic      rec_stall,
  input rec_word_t rec_word
);

  a_stall_needs_record: assert property (@(posedge clk) disable iff (rst)
    es_stall |-> rec_valid)
    else $error("byte side stalled with no record waiting");

  a_stall_after_backpressure: assert property (@(posedge clk) disable iff (rst)
    $rose(es_stall) |-> $past(rec_valid && rec_stall))
    else $error("byte side stall rose without a stalled record");

  a_picture_fields: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (rec_word.record_kind == REC_PICTURE) |->
      (rec_word.picture_type != PIC_NONE) &&
      (rec_word.starts_entry == (rec_word.picture_type == PIC_I)) &&
      (rec_word.width == '0) && (rec_word.height == '0) &&
      (rec_word.aspect_code == '0) && (rec_word.frame_rate == '0))
    else $error("malformed picture record");

  a_sequence_fields: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (rec_word.record_kind == REC_SEQUENCE) |->
      (rec_word.picture_type == PIC_NONE) && !rec_word.starts_entry &&
      (rec_word.width[3:0] == 4'd0) && (rec_word.height[3:0] == 4'd0))
    else $error("malformed sequence record");

  a_record_held: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(rec_word))
    else $error("stalled record word changed");

endmodule

bind mpeg2_video_start_code_indexer msci_checker u_msci_checker (
  .clk      (clk),
  .rst      (rst),
  .es_stall (es_stall),
  .rec_valid(rec_valid),
  .rec_stall(rec_stall),
  .rec_word (rec_word)
);

>>> dv/mpeg2_video_start_code_indexer_test.sv
// Self-checking testbench for the MPEG-2 video start code indexer with a byte-level predictor.
module mpeg2_video_start_code_indexer_test;
  import msci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TYPE_NONE     = 3'd0;
  localparam logic [2:0] TYPE_I        = 3'd1;
  localparam logic [2:0] TYPE_P        = 3'd2;
  localparam logic [2:0] TYPE_B        = 3'd3;
  localparam logic [2:0] TYPE_RESERVED = 3'd7;
  localparam logic [7:0] PREFIX_ZERO   = 8'h00;
  localparam logic [7:0] PREFIX_ONE    = 8'h01;
  localparam entry_pos_t POS_ALL_ONES  = '1;

  logic      clk;
  logic      rst;
  logic      es_valid;
  logic      es_stall;
  es_word_t  es_word;
  logic      rec_valid;
  logic      rec_stall;
  rec_word_t rec_word;

  // Predictor state.
  logic [23:0] win;
  logic        seq_seen;
  logic        entry_locked;
  hdr_kind_t   hdr_kind;
  logic [3:0]  hdr_left;
  logic [31:0] hdr_bits;
  entry_pos_t  entry_pos;
  entry_pos_t  pic_pos;

  rec_word_t   expected_records[$];
  int          errors;
  int          bytes_sent;
  int          send_gap_pct;
  int          stall_pct;
  entry_pos_t  next_pos;

  mpeg2_video_start_code_indexer u_dut (
    .clk       (clk),
    .rst       (rst),
    .es_valid  (es_valid),
    .es_stall  (es_stall),
    .es_word   (es_word),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_word  (rec_word)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [12:0] size_up16(input logic [11:0] v);
    return (13'(v) + 13'd15) & 13'h1FF0;
  endfunction

  function automatic logic [15:0] rate_milli(input logic [3:0] code);
    logic [15:0] lut [0:15];
    lut = '{16'd0, 16'd23976, 16'd24000, 16'd25000, 16'd29970, 16'd30000, 16'd50000,
            16'd59940, 16'd60000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    return lut[code];
  endfunction

  task automatic reset_predictor();
    win          = WINDOW_ONES;
    seq_seen     = 1'b0;
    entry_locked = 1'b0;
    hdr_kind     = HK_SCAN;
    hdr_left     = '0;
    hdr_bits     = '0;
    entry_pos    = '0;
    pic_pos      = '0;
  endtask

  task automatic predict_record(input logic [7:0] b, input entry_pos_t p);
    rec_word_t  r;
    logic       last;
    logic [2:0] ptype;
    if (hdr_kind == HK_SCAN) begin
      if (win != WINDOW_PREFIX) begin
        win = {win[15:0], b};
      end else begin
        win = WINDOW_ONES;
        if (b == CODE_SEQUENCE) begin
          entry_pos    = p;
          entry_locked = 1'b1;
          hdr_bits     = '0;
          if (seq_seen) begin
            hdr_kind = HK_SKIP;
            hdr_left = SEQ_SKIP_BYTES;
          end else begin
            seq_seen = 1'b1;
            hdr_kind = HK_SEQ;
            hdr_left = SEQ_FIELD_BYTES;
          end
        end else if (b == CODE_GOP) begin
          if (seq_seen && !entry_locked) begin
            entry_pos    = p;
            entry_locked = 1'b1;
          end
        end else if (b == CODE_PICTURE) begin
          if (seq_seen) begin
            hdr_kind = HK_PIC;
            hdr_left = PIC_FIELD_BYTES;
            hdr_bits = '0;
            pic_pos  = p;
          end
        end
      end
    end else begin
      last     = (hdr_left <= 4'd1);
      hdr_left = last ? 4'd0 : hdr_left - 4'd1;
      if (hdr_kind == HK_SKIP) begin
        if (last) hdr_kind = HK_SCAN;
      end else begin
        hdr_bits = {hdr_bits[23:0], b};
        if (last) begin
          r = '0;
          if (hdr_kind == HK_SEQ) begin
            r.record_kind = REC_SEQUENCE;
            r.entry_start = entry_pos;
            r.width       = size_up16(hdr_bits[31:20]);
            r.height      = size_up16(hdr_bits[19:8]);
            r.aspect_code = hdr_bits[7:4];
            r.frame_rate  = rate_milli(hdr_bits[3:0]);
            expected_records.push_back(r);
            hdr_kind = HK_SKIP;
            hdr_left = SEQ_TAIL_BYTES;
          end else begin
            ptype    = hdr_bits[5:3];
            hdr_kind = HK_SCAN;
            if (ptype >= TYPE_I && ptype <= TYPE_B) begin
              r.record_kind  = REC_PICTURE;
              r.entry_start  = entry_pos;
              r.picture_type = ptype[1:0];
              r.starts_entry = (ptype == TYPE_I);
              expected_records.push_back(r);
              if (!entry_locked) entry_pos = pic_pos;
              entry_locked = 1'b0;
            end
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic send_word(input logic [7:0] b, input entry_pos_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      es_valid <= 1'b0;
    end
    @(negedge clk);
    es_valid              <= 1'b1;
    es_word.es_byte       <= b;
    es_word.byte_position <= p;
    do @(posedge clk); while (es_stall);
    predict_record(b, p);
    bytes_sent++;
  endtask

  task automatic send_stream_byte(input logic [7:0] b);
    if ($urandom_range(7) == 0) next_pos = entry_pos_t'({$urandom, $urandom});
    else next_pos = next_pos + 1'b1;
    send_word(b, next_pos);
  endtask

  task automatic send_start_code(input logic [7:0] code);
    send_stream_byte(PREFIX_ZERO);
    send_stream_byte(PREFIX_ZERO);
    send_stream_byte(PREFIX_ONE);
    send_stream_byte(code);
  endtask

  task automatic send_sequence(input logic [11:0] h, input logic [11:0] v,
                               input logic [3:0] aspect, input logic [3:0] rate);
    send_start_code(CODE_SEQUENCE);
    send_stream_byte(h[11:4]);
    send_stream_byte({h[3:0], v[11:8]});
    send_stream_byte(v[7:0]);
    send_stream_byte({aspect, rate});
    repeat (4) send_stream_byte(8'($urandom));
  endtask

  task automatic send_picture(input logic [2:0] ptype);
    logic [7:0] tail;
    tail      = 8'($urandom);
    tail[5:3] = ptype;
    send_start_code(CODE_PICTURE);
    send_stream_byte(8'($urandom));
    send_stream_byte(tail);
  endtask

  task automatic send_noise();
    int n;
    int pick;
    n = $urandom_range(6, 1);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick < 3) send_stream_byte(PREFIX_ZERO);
      else if (pick < 5) send_stream_byte(PREFIX_ONE);
      else if (pick == 5) send_stream_byte(CODE_SEQUENCE);
      else if (pick == 6) send_stream_byte(CODE_GOP);
      else send_stream_byte(8'($urandom));
    end
  endtask

  task automatic random_stream(input int stop_at);
    int         pick;
    logic [2:0] ptype;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_sequence(12'($urandom), 12'($urandom), 4'($urandom), 4'($urandom));
      end else if (pick < 25) begin
        send_start_code(CODE_GOP);
        repeat (4) send_stream_byte(8'($urandom));
      end else if (pick < 70) begin
        if ($urandom_range(99) < 85) ptype = 3'($urandom_range(3, 1));
        else begin
          ptype = 3'($urandom_range(7, 3));
          if (ptype == TYPE_B) ptype = TYPE_NONE;
        end
        send_picture(ptype);
      end else if (pick < 85) begin
        send_noise();
      end else begin
        send_stream_byte(PREFIX_ZERO);
        send_stream_byte(PREFIX_ZERO);
        if ($urandom_range(1)) send_stream_byte(PREFIX_ONE);
        send_stream_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_directed_headers();
    // Picture and group ahead of any sequence header are ignored.
    send_start_code(CODE_PICTURE);
    send_start_code(CODE_GOP);
    next_pos = POS_ALL_ONES - entry_pos_t'(3);
    send_sequence(12'hFFF, 12'h001, 4'hF, 4'd7);
    send_start_code(CODE_GOP);
    next_pos = POS_ALL_ONES - entry_pos_t'(3);
    send_picture(TYPE_I);
    send_picture(TYPE_RESERVED);
    send_picture(TYPE_B);
    send_start_code(CODE_GOP);
    send_picture(TYPE_P);
  endtask

  task automatic test_random_slow_receiver();
    send_gap_pct = 10;
    stall_pct    = 62;
    random_stream(bytes_sent + 300);
  endtask

  task automatic test_random_slow_sender();
    send_gap_pct = 62;
    stall_pct    = 10;
    random_stream(bytes_sent + 300);
  endtask

  task automatic test_random_full_rate();
    send_gap_pct = 0;
    stall_pct    = 0;
    random_stream(bytes_sent + 300);
  endtask

  always @(negedge clk) begin
    rec_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    rec_word_t want;
    if (!rst && rec_valid && !rec_stall) begin
      if (expected_records.size() == 0) begin
        report_mismatch("unexpected record, entry start", 64'(rec_word.entry_start), 64'd0);
      end else begin
        want = expected_records.pop_front();
        if (rec_word.record_kind !== want.record_kind)
          report_mismatch("record_kind", 64'(rec_word.record_kind), 64'(want.record_kind));
        if (rec_word.entry_start !== want.entry_start)
          report_mismatch("entry_start", 64'(rec_word.entry_start), 64'(want.entry_start));
        if (rec_word.picture_type !== want.picture_type)
          report_mismatch("picture_type", 64'(rec_word.picture_type), 64'(want.picture_type));
        if (rec_word.starts_entry !== want.starts_entry)
          report_mismatch("starts_entry", 64'(rec_word.starts_entry), 64'(want.starts_entry));
        if (rec_word.width !== want.width)
          report_mismatch("width", 64'(rec_word.width), 64'(want.width));
        if (rec_word.height !== want.height)
          report_mismatch("height", 64'(rec_word.height), 64'(want.height));
        if (rec_word.aspect_code !== want.aspect_code)
          report_mismatch("aspect_code", 64'(rec_word.aspect_code), 64'(want.aspect_code));
        if (rec_word.frame_rate !== want.frame_rate)
          report_mismatch("frame_rate", 64'(rec_word.frame_rate), 64'(want.frame_rate));
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL mpeg2_video_start_code_indexer");
    $finish;
  end

  initial begin
    errors       = 0;
    bytes_sent   = 0;
    send_gap_pct = 10;
    stall_pct    = 62;
    next_pos     = '0;
    rst          = 1'b1;
    es_valid     = 1'b0;
    es_word      = '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_headers();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    @(negedge clk);
    es_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS mpeg2_video_start_code_indexer");
    end else begin
      $display("FAIL mpeg2_video_start_code_indexer");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/msci_pkg.sv
rtl/core/msci_scan.sv
rtl/core/mpeg2_video_start_code_indexer.sv
rtl/core/msci_checker.sv
dv/mpeg2_video_start_code_indexer_test.sv
